>>> rtl/motor_direction_interlock_fsm_assert.svh
// Assertion macros for the motor interlock RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef MOTOR_DIRECTION_INTERLOCK_FSM_ASSERT_SVH
`define MOTOR_DIRECTION_INTERLOCK_FSM_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, off while reset is held
`define MDI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mdi assertion failed");

// Condition implies consequence in the same cycle
`define MDI_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("mdi assertion failed");

// Condition implies consequence in the next cycle
`define MDI_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("mdi assertion failed");

`else

`define MDI_ASSERT(label, clk, rst_n, prop)
`define MDI_ASSERT_IMPL(label, clk, rst_n, cond, cons)
`define MDI_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

>>> rtl/mdi_pkg.sv
// Types and constants of the motor direction interlock.
// Used by mdi_cfg, mdi_ctrl and motor_direction_interlock_fsm; no dependencies.
`default_nettype none

package mdi_pkg;

    // Per-motor state machine states
    typedef enum logic [2:0] {
        MS_STOPPED   = 3'd0,
        MS_RUNNING   = 3'd1,
        MS_BRAKING   = 3'd2,
        MS_REVERSING = 3'd3,
        MS_ESTOP     = 3'd4,
        MS_FAULT     = 3'd5
    } mstate_t;

    // Command codes
    typedef enum logic [3:0] {
        ACT_SPEED     = 4'd0,
        ACT_DIRECTION = 4'd1,
        ACT_ENABLE    = 4'd2,
        ACT_BRAKE     = 4'd3,
        ACT_ESTOP     = 4'd4,
        ACT_CLEAR     = 4'd5,
        ACT_REPORT    = 4'd6,
        ACT_TICK      = 4'd7,
        ACT_QUERY     = 4'd8
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_RANGE  = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MOTOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_REVERSE_WAIT = 2'd1;

    localparam logic [15:0] STOP_RPM = 16'd5;
    localparam logic [15:0] MIN_WAIT = 16'd100;

    // Input item, packed so the last field sits in the lowest bits
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] rpm;
        logic [7:0]  fault_bits;
        logic        enable_req;
        logic        direction_req;
        logic [7:0]  speed_req;
        logic [1:0]  motor;
        logic [3:0]  action;
    } cmd_t;

    // Result item, same packing rule
    typedef struct packed {
        logic        estop_pulse;
        logic [7:0]  faults_out;
        logic        brake_out;
        logic        enable_out;
        logic [7:0]  speed_out;
        logic        direction_out;
        logic [2:0]  motor_state;
        logic [1:0]  motor_out;
        logic [1:0]  status;
    } res_t;

    // Context of one motor
    typedef struct packed {
        mstate_t     mstate;
        logic        cur_dir;
        logic        req_dir;
        logic [7:0]  speed_set;
        logic [7:0]  fault_mask;
        logic        enabled;
        logic        braking;
        logic [31:0] reverse_start;
    } motor_t;

    localparam motor_t MOTOR_RST = '{
        mstate:        MS_STOPPED,
        cur_dir:       1'b0,
        req_dir:       1'b0,
        speed_set:     8'd0,
        fault_mask:    8'd0,
        enabled:       1'b0,
        braking:       1'b1,
        reverse_start: 32'd0
    };

endpackage

`default_nettype wire

>>> rtl/mdi_cfg.sv
// Configuration registers of the motor interlock: motor count and reversal wait.
// Depends on mdi_pkg for the register indexes and the minimum wait.
`default_nettype none

module mdi_cfg
    import mdi_pkg::*;
#(
    parameter int MOTORS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic [2:0]       motors_used,
    output logic [15:0]      reverse_wait
);

    logic [2:0]  count_reg;
    logic [15:0] wait_reg;
    logic [2:0]  count_sat;
    logic [15:0] wait_sat;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;

    // Saturate written values into their legal ranges
    always_comb begin
        count_sat = cfg_data[2:0];
        if (count_sat == 3'd0) begin
            count_sat = 3'd1;
        end else if (int'(count_sat) > MOTORS) begin
            count_sat = 3'(MOTORS);
        end
        wait_sat = (cfg_data < MIN_WAIT) ? MIN_WAIT : cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd1;
            wait_reg  <= MIN_WAIT;
        end else if (wr) begin
            case (cfg_index)
                CFG_MOTOR_COUNT:  count_reg <= count_sat;
                CFG_REVERSE_WAIT: wait_reg  <= wait_sat;
                default: ;
            endcase
        end
    end

    assign motors_used  = count_reg;
    assign reverse_wait = wait_reg;

endmodule

`default_nettype wire

>>> rtl/mdi_ctrl.sv
// Per-motor context table and the command state machine of the motor interlock.
// Depends on mdi_pkg for the command, result and context types.
`default_nettype none

module mdi_ctrl
    import mdi_pkg::*;
#(
    parameter int MOTORS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        upd,
    input  wire cmd_t        cmd,
    input  wire logic [2:0]  motors_used,
    input  wire logic [15:0] reverse_wait,
    output res_t             res
);

    motor_t  tbl_reg [MOTORS];
    motor_t  cur;
    motor_t  entry_next;
    mstate_t s;
    status_t status;
    action_t act;
    logic    in_range;
    logic    is_estop;
    logic    stopped_rpm;
    logic [31:0] elapsed;

    assign act         = action_t'(cmd.action);
    assign is_estop    = (act == ACT_ESTOP);
    assign in_range    = ({1'b0, cmd.motor} < motors_used) && (int'(cmd.motor) < MOTORS);
    assign stopped_rpm = (cmd.rpm < STOP_RPM);

    // Read the addressed motor
    always_comb begin
        cur = MOTOR_RST;
        for (int k = 0; k < MOTORS; k++) begin
            if (int'(cmd.motor) == k) begin
                cur = tbl_reg[k];
            end
        end
    end

    assign s       = cur.mstate;
    assign elapsed = cmd.now_ms - cur.reverse_start;

    // Next context of the addressed motor
    always_comb begin
        entry_next = cur;
        status     = STAT_OK;
        case (act)
            ACT_SPEED: begin
                if (s inside {MS_ESTOP, MS_FAULT, MS_REVERSING}) begin
                    status = STAT_REJECT;
                end else begin
                    entry_next.speed_set = cmd.speed_req;
                    if (cmd.speed_req == 8'd0) begin
                        entry_next.mstate = MS_STOPPED;
                    end else if (s inside {MS_STOPPED, MS_BRAKING}) begin
                        entry_next.braking = 1'b0;
                        entry_next.mstate  = MS_RUNNING;
                    end
                end
            end
            ACT_DIRECTION: begin
                if (s inside {MS_ESTOP, MS_FAULT, MS_REVERSING}) begin
                    status = STAT_REJECT;
                end else if (cur.cur_dir != cmd.direction_req) begin
                    entry_next.req_dir = cmd.direction_req;
                    if (s == MS_STOPPED && cur.speed_set == 8'd0) begin
                        entry_next.mstate        = MS_REVERSING;
                        entry_next.reverse_start = cmd.now_ms;
                    end else begin
                        entry_next.speed_set = 8'd0;
                        entry_next.braking   = 1'b1;
                        entry_next.mstate    = MS_BRAKING;
                    end
                end
            end
            ACT_ENABLE: begin
                if ((s inside {MS_ESTOP, MS_FAULT}) && cmd.enable_req) begin
                    status = STAT_REJECT;
                end else begin
                    entry_next.enabled = cmd.enable_req;
                    if (!cmd.enable_req && s == MS_RUNNING) begin
                        entry_next.speed_set = 8'd0;
                        entry_next.mstate    = MS_STOPPED;
                    end
                end
            end
            ACT_BRAKE: begin
                entry_next.speed_set = 8'd0;
                entry_next.braking   = 1'b1;
                if (s == MS_RUNNING) begin
                    entry_next.mstate = MS_BRAKING;
                end
            end
            ACT_ESTOP: ;
            ACT_CLEAR: begin
                if (s inside {MS_ESTOP, MS_FAULT}) begin
                    if (cmd.fault_bits != 8'd0 && s == MS_FAULT) begin
                        status = STAT_REJECT;
                    end else begin
                        entry_next.mstate     = MS_STOPPED;
                        entry_next.fault_mask = 8'd0;
                        entry_next.speed_set  = 8'd0;
                    end
                end
            end
            ACT_REPORT: begin
                entry_next.mstate     = MS_FAULT;
                entry_next.fault_mask = cmd.fault_bits;
                entry_next.speed_set  = 8'd0;
                entry_next.enabled    = 1'b0;
                entry_next.braking    = 1'b1;
            end
            ACT_TICK: begin
                if (s != MS_ESTOP) begin
                    if (s != MS_FAULT && cmd.fault_bits != 8'd0) begin
                        entry_next.mstate     = MS_FAULT;
                        entry_next.fault_mask = cmd.fault_bits;
                        entry_next.speed_set  = 8'd0;
                        entry_next.enabled    = 1'b0;
                        entry_next.braking    = 1'b1;
                    end else if (s == MS_BRAKING && stopped_rpm) begin
                        // a fresh reversal starts its wait now, so it cannot commit yet
                        if (cur.req_dir != cur.cur_dir) begin
                            entry_next.mstate        = MS_REVERSING;
                            entry_next.reverse_start = cmd.now_ms;
                        end else begin
                            entry_next.mstate  = MS_STOPPED;
                            entry_next.braking = 1'b0;
                        end
                    end else if (s == MS_REVERSING && stopped_rpm
                                 && elapsed >= {16'd0, reverse_wait}) begin
                        entry_next.cur_dir = cur.req_dir;
                        entry_next.mstate  = MS_STOPPED;
                        entry_next.braking = 1'b0;
                    end
                end
            end
            ACT_QUERY: ;
            default: status = STAT_REJECT;
        endcase
    end

    // Table update: estop sweeps every configured motor, others touch one entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOTORS; k++) begin
                tbl_reg[k] <= MOTOR_RST;
            end
        end else if (upd) begin
            for (int k = 0; k < MOTORS; k++) begin
                if (is_estop) begin
                    if (k < int'(motors_used)) begin
                        tbl_reg[k].mstate    <= MS_ESTOP;
                        tbl_reg[k].speed_set <= 8'd0;
                        tbl_reg[k].enabled   <= 1'b0;
                        tbl_reg[k].braking   <= 1'b1;
                    end
                end else if (in_range && int'(cmd.motor) == k) begin
                    tbl_reg[k] <= entry_next;
                end
            end
        end
    end

    // Result item
    always_comb begin
        res = '0;
        if (is_estop) begin
            res.status        = STAT_OK;
            res.motor_out     = 2'd0;
            res.motor_state   = MS_ESTOP;
            res.direction_out = tbl_reg[0].cur_dir;
            res.speed_out     = 8'd0;
            res.enable_out    = 1'b0;
            res.brake_out     = 1'b1;
            res.faults_out    = tbl_reg[0].fault_mask;
            res.estop_pulse   = 1'b1;
        end else if (!in_range) begin
            res.status    = STAT_RANGE;
            res.motor_out = cmd.motor;
        end else begin
            res.status        = status;
            res.motor_out     = cmd.motor;
            res.motor_state   = entry_next.mstate;
            res.direction_out = entry_next.cur_dir;
            res.speed_out     = entry_next.speed_set;
            res.enable_out    = entry_next.enabled;
            res.brake_out     = entry_next.braking;
            res.faults_out    = entry_next.fault_mask;
            res.estop_pulse   = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/motor_direction_interlock_fsm.sv
// Motor direction interlock: per-motor safety state machine with stream ports.
// Usage:
//   s_* channel takes one command item per handshake (tvalid & tready).
//   m_* channel returns exactly one result item for every command.
//   cfg_* channel writes the motor count (index 0) and reverse_wait_ms (index 1);
//   cfg_ready is always high, writes are meant to happen while no item is in flight.
// Timing:
//   An item is captured in an input register and evaluated against the motor table;
//   the result lands in the output register, which drives m_tvalid. The input
//   register holds while the output is full and m_tready low. One item per cycle
//   sustained while m_tready is high, set by the single table read-modify-write.
// Stall:
//   While the receiver holds m_tready low the result stays in the output
//   register and one more item waits in the input register; s_tready falls
//   only when both are full.
// Reset (aresetn low, synchronous): all motors stopped, braked, direction 0,
//   motor count 1, reverse_wait_ms 100, both pipeline registers empty.
// Depends on mdi_pkg, mdi_cfg, mdi_ctrl and the assertion macro header.
`default_nettype none
`include "motor_direction_interlock_fsm_assert.svh"

module motor_direction_interlock_fsm
    import mdi_pkg::*;
#(
    parameter int MOTORS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: action[3:0], motor[5:4], speed_req[13:6], direction_req[14],
    //        enable_req[15], fault_bits[23:16], rpm[39:24], now_ms[71:40]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,
    // tdata: status[1:0], motor_out[3:2], motor_state[6:4], direction_out[7],
    //        speed_out[15:8], enable_out[16], brake_out[17], faults_out[25:18],
    //        estop_pulse[26], zero[31:27]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_vld_reg;
    cmd_t        in_data_reg;
    logic        out_vld_reg;
    res_t        out_reg;
    res_t        res;
    logic        fire;
    logic        s_acc;
    logic [2:0]  motors_used;
    logic [15:0] reverse_wait;

    mdi_cfg #(
        .MOTORS(MOTORS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .motors_used  (motors_used),
        .reverse_wait (reverse_wait)
    );

    mdi_ctrl #(
        .MOTORS(MOTORS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (fire),
        .cmd          (in_data_reg),
        .motors_used  (motors_used),
        .reverse_wait (reverse_wait),
        .res          (res)
    );

    // Pipeline control
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign s_acc    = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_acc) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_data_reg <= cmd_t'(s_tdata);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reg};

    // Checks
    `MDI_ASSERT_NEXT(a_fire_loads_out, aclk, aresetn, fire, out_vld_reg)
    `MDI_ASSERT_NEXT(a_stall_keeps_in, aclk, aresetn,
                     in_vld_reg && out_vld_reg && !m_tready, in_vld_reg)
    `MDI_ASSERT_IMPL(a_estop_result, aclk, aresetn, out_vld_reg && out_reg.estop_pulse,
                     out_reg.status == STAT_OK && out_reg.motor_state == MS_ESTOP
                     && out_reg.motor_out == 2'd0)
    `MDI_ASSERT_IMPL(a_range_zero, aclk, aresetn,
                     out_vld_reg && out_reg.status == STAT_RANGE,
                     out_reg.speed_out == 8'd0 && !out_reg.enable_out && !out_reg.estop_pulse)
    `MDI_ASSERT(a_count_legal, aclk, aresetn,
                motors_used != 3'd0 && int'(motors_used) <= MOTORS)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for motor_direction_interlock_fsm: a directed command table,
// then random traffic under several register settings, checked by an in-bench model and fixed expected items.
// Depends on mdi_pkg and the RTL of motor_direction_interlock_fsm.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdi_pkg::*;

    localparam int NUM_MOTORS = 4;
    localparam int LIMIT      = 200000;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 62;

    // Action codes with no command behind them
    localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

    // Register settings per random phase: count writes include saturating values
    localparam logic [15:0] COUNT_SET [PHASES] = '{16'hFFFF, 16'd2, 16'd0, 16'd4, 16'd3, 16'd4};
    localparam logic [15:0] WAIT_SET  [PHASES] = '{16'd0, 16'hFFFF, 16'd99, 16'd1000, 16'd250,
                                                   16'd100};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;   // action, motor, speed_req, direction_req, enable_req,
                                   // fault_bits, rpm, now_ms (low bits first)
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // status, motor_out, motor_state, direction_out, speed_out,
                                   // enable_out, brake_out, faults_out, estop_pulse, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    motor_direction_interlock_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Model copy of the motor table and registers
    mstate_t     mst    [NUM_MOTORS];
    logic        cdir   [NUM_MOTORS];
    logic        pdir   [NUM_MOTORS];
    logic [7:0]  spd    [NUM_MOTORS];
    logic [7:0]  fmask  [NUM_MOTORS];
    logic        en     [NUM_MOTORS];
    logic        brk    [NUM_MOTORS];
    logic [31:0] rstart [NUM_MOTORS];
    int          motor_cnt = 1;
    logic [15:0] wait_ms   = MIN_WAIT;

    res_t drive_exp_q [$];
    int   bad_results = 0;
    int   results_seen = 0;
    int   cycles = 0;
    int   burst_left = 0;
    logic [31:0] wall_ms;

    typedef struct {
        cmd_t cmd;
        bit   typed;
        res_t want;
    } script_row_t;
    script_row_t script_rows [$];

    // Drive values of one motor as the block reports them
    function automatic res_t drive_view(status_t st, int m, logic pulse);
        res_t r;
        r.status        = st;
        r.motor_out     = m[1:0];
        r.motor_state   = mst[m];
        r.direction_out = cdir[m];
        r.speed_out     = spd[m];
        r.enable_out    = en[m];
        r.brake_out     = brk[m];
        r.faults_out    = fmask[m];
        r.estop_pulse   = pulse;
        return r;
    endfunction

    function automatic void latch_fault(int m, logic [7:0] mask);
        mst[m]   = MS_FAULT;
        fmask[m] = mask;
        spd[m]   = 8'd0;
        en[m]    = 1'b0;
        brk[m]   = 1'b1;
    endfunction

    // One command applied to the motor table; returns the result item it causes
    function automatic res_t interlock_step(cmd_t c);
        int          m;
        mstate_t     s;
        status_t     st;
        logic [31:0] elapsed;
        res_t        r;
        m  = int'(c.motor);
        st = STAT_OK;
        if (c.action == ACT_ESTOP) begin
            for (int k = 0; k < motor_cnt; k++) begin
                mst[k] = MS_ESTOP;
                spd[k] = 8'd0;
                en[k]  = 1'b0;
                brk[k] = 1'b1;
            end
            return drive_view(STAT_OK, 0, 1'b1);
        end
        if (m >= motor_cnt) begin
            r           = '0;
            r.status    = STAT_RANGE;
            r.motor_out = c.motor;
            return r;
        end
        s = mst[m];
        case (c.action)
            ACT_SPEED: begin
                if (s == MS_ESTOP || s == MS_FAULT || s == MS_REVERSING) begin
                    st = STAT_REJECT;
                end else begin
                    spd[m] = c.speed_req;
                    if (c.speed_req == 8'd0) begin
                        mst[m] = MS_STOPPED;
                    end else if (s == MS_STOPPED || s == MS_BRAKING) begin
                        brk[m] = 1'b0;
                        mst[m] = MS_RUNNING;
                    end
                end
            end
            ACT_DIRECTION: begin
                if (s == MS_ESTOP || s == MS_FAULT || s == MS_REVERSING) begin
                    st = STAT_REJECT;
                end else if (cdir[m] != c.direction_req) begin
                    pdir[m] = c.direction_req;
                    if (s == MS_STOPPED && spd[m] == 8'd0) begin
                        mst[m]    = MS_REVERSING;
                        rstart[m] = c.now_ms;
                    end else begin
                        spd[m] = 8'd0;
                        brk[m] = 1'b1;
                        mst[m] = MS_BRAKING;
                    end
                end
            end
            ACT_ENABLE: begin
                if ((s == MS_ESTOP || s == MS_FAULT) && c.enable_req) begin
                    st = STAT_REJECT;
                end else begin
                    en[m] = c.enable_req;
                    if (!c.enable_req && s == MS_RUNNING) begin
                        spd[m] = 8'd0;
                        mst[m] = MS_STOPPED;
                    end
                end
            end
            ACT_BRAKE: begin
                spd[m] = 8'd0;
                brk[m] = 1'b1;
                if (s == MS_RUNNING) mst[m] = MS_BRAKING;
            end
            ACT_CLEAR: begin
                if (s == MS_ESTOP || s == MS_FAULT) begin
                    if (c.fault_bits != 8'd0 && s == MS_FAULT) begin
                        st = STAT_REJECT;
                    end else begin
                        mst[m]   = MS_STOPPED;
                        fmask[m] = 8'd0;
                        spd[m]   = 8'd0;
                    end
                end
            end
            ACT_REPORT: latch_fault(m, c.fault_bits);
            ACT_TICK: begin
                if (s != MS_ESTOP) begin
                    if (s != MS_FAULT && c.fault_bits != 8'd0) begin
                        latch_fault(m, c.fault_bits);
                    end else begin
                        // braked down to standstill: start the wait or just stop
                        if (mst[m] == MS_BRAKING && c.rpm < STOP_RPM) begin
                            if (pdir[m] != cdir[m]) begin
                                mst[m]    = MS_REVERSING;
                                rstart[m] = c.now_ms;
                            end else begin
                                mst[m] = MS_STOPPED;
                                brk[m] = 1'b0;
                            end
                        end
                        // commit once the wait has run out, time wraps
                        if (mst[m] == MS_REVERSING) begin
                            elapsed = c.now_ms - rstart[m];
                            if (elapsed >= {16'd0, wait_ms} && c.rpm < STOP_RPM) begin
                                cdir[m] = pdir[m];
                                mst[m]  = MS_STOPPED;
                                brk[m]  = 1'b0;
                            end
                        end
                    end
                end
            end
            ACT_QUERY: ;
            default: st = STAT_REJECT;
        endcase
        return drive_view(st, m, 1'b0);
    endfunction

    function automatic void set_reg(logic [1:0] idx, logic [15:0] v);
        if (idx == CFG_MOTOR_COUNT) begin
            motor_cnt = int'(v[2:0]);
            if (motor_cnt < 1) motor_cnt = 1;
            if (motor_cnt > NUM_MOTORS) motor_cnt = NUM_MOTORS;
        end else if (idx == CFG_REVERSE_WAIT) begin
            wait_ms = (v < MIN_WAIT) ? MIN_WAIT : v;
        end
    endfunction

    function automatic string fmt_res(res_t r);
        return $sformatf("st=%0d m=%0d state=%0d dir=%0d spd=%0d en=%0d brk=%0d flt=%02h pulse=%0d",
                         r.status, r.motor_out, r.motor_state, r.direction_out, r.speed_out,
                         r.enable_out, r.brake_out, r.faults_out, r.estop_pulse);
    endfunction

    // Compare one result item with the oldest expectation
    function automatic void check_result(logic [31:0] word);
        res_t got;
        res_t want;
        got = word[26:0];
        if (drive_exp_q.size() == 0) begin
            bad_results++;
            if (bad_results <= 10) $display("unexpected result item: %s", fmt_res(got));
            return;
        end
        want = drive_exp_q.pop_front();
        results_seen++;
        if (got.status !== want.status || got.motor_out !== want.motor_out
            || got.motor_state !== want.motor_state || got.direction_out !== want.direction_out
            || got.speed_out !== want.speed_out || got.enable_out !== want.enable_out
            || got.brake_out !== want.brake_out || got.faults_out !== want.faults_out
            || got.estop_pulse !== want.estop_pulse || word[31:27] !== 5'd0) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("result %0d mismatch, expected %s", results_seen, fmt_res(want));
                $display("  got %s pad=%0h", fmt_res(got), word[31:27]);
            end
        end
    endfunction

    function automatic cmd_t mk(logic [3:0] a, logic [1:0] m, logic [7:0] sp, logic d, logic e,
                                logic [7:0] fb, logic [15:0] rpm, logic [31:0] t);
        cmd_t c;
        c.action        = a;
        c.motor         = m;
        c.speed_req     = sp;
        c.direction_req = d;
        c.enable_req    = e;
        c.fault_bits    = fb;
        c.rpm           = rpm;
        c.now_ms        = t;
        return c;
    endfunction

    function automatic void row(cmd_t c);
        script_rows.push_back('{c, 1'b0, res_t'(0)});
    endfunction

    function automatic void row_chk(cmd_t c, res_t w);
        script_rows.push_back('{c, 1'b1, w});
    endfunction

    // Receiver: check accepted items, stall in changing patterns
    int       rx_phase = 0;
    int       rx_mode  = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        rx_phase <= rx_phase + 1;
        if (rx_phase % 48 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 6);
            2: m_tready <= (rx_phase % 5 != 0);
            default: m_tready <= (rx_phase % 16 < 8);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one command item; sender idles between bursts
    task automatic feed(cmd_t c, bit typed, res_t want);
        res_t r;
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = interlock_step(c);
        if (typed) r = want;
        drive_exp_q.push_back(r);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Drain all results, then let the pipeline settle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (drive_exp_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        set_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random commands, weighted toward ticks and the reversal path
    task automatic run_traffic(int n);
        cmd_t c;
        int   pick;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 3) wall_ms = $urandom();
            else wall_ms = wall_ms + $urandom_range(0, wait_ms / 3);
            pick = $urandom_range(0, 99);
            c.now_ms        = wall_ms;
            c.speed_req     = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            c.direction_req = 1'($urandom_range(0, 1));
            c.enable_req    = 1'($urandom_range(0, 1));
            c.fault_bits    = 8'($urandom_range(0, 255));
            c.rpm           = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8))
                                                         : 16'($urandom_range(0, 65535));
            c.motor         = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, motor_cnt - 1))
                                                           : 2'($urandom_range(0, 3));
            if (pick < 30) begin
                c.action = ACT_TICK;
                if ($urandom_range(0, 99) >= 8) c.fault_bits = 8'd0;
            end else if (pick < 45) c.action = ACT_SPEED;
            else if (pick < 60) c.action = ACT_DIRECTION;
            else if (pick < 68) c.action = ACT_ENABLE;
            else if (pick < 74) c.action = ACT_BRAKE;
            else if (pick < 82) begin
                c.action = ACT_CLEAR;
                if ($urandom_range(0, 9) < 7) c.fault_bits = 8'd0;
            end else if (pick < 86) c.action = ACT_REPORT;
            else if (pick < 92) c.action = ACT_QUERY;
            else if (pick < 95) c.action = ACT_ESTOP;
            else c.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            feed(c, 1'b0, res_t'(0));
        end
    endtask

    res_t reset_view;
    res_t range_view;

    initial begin
        for (int k = 0; k < NUM_MOTORS; k++) begin
            mst[k]    = MS_STOPPED;
            cdir[k]   = 1'b0;
            pdir[k]   = 1'b0;
            spd[k]    = 8'd0;
            fmask[k]  = 8'd0;
            en[k]     = 1'b0;
            brk[k]    = 1'b1;
            rstart[k] = 32'd0;
        end
        wall_ms    = $urandom();
        reset_view = '{status: STAT_OK, motor_out: 2'd0, motor_state: MS_STOPPED,
                       direction_out: 1'b0, speed_out: 8'd0, enable_out: 1'b0,
                       brake_out: 1'b1, faults_out: 8'd0, estop_pulse: 1'b0};
        range_view = '{status: STAT_RANGE, motor_out: 2'd3, default: '0};

        // Directed table, reset settings: one motor, minimum wait
        row_chk(mk(ACT_QUERY, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd0), reset_view);
        row_chk(mk(ACT_SPEED, 2'd3, 8'hFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF),
                range_view);
        reset_view.status = STAT_REJECT;
        row_chk(mk(ACT_UNUSED_HI, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd0), reset_view);
        row(mk(ACT_SPEED, 2'd0, 8'hFF, 1'b0, 1'b0, 8'd0, 16'd0, 32'd0));
        row(mk(ACT_DIRECTION, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd0));
        row(mk(ACT_DIRECTION, 2'd0, 8'd0, 1'b1, 1'b0, 8'd0, 16'd0, 32'd0));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'hFFFF, 32'd0));
        // reversal wait straddles the wrap of the ms counter
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'hFFFF_FF00));
        row(mk(ACT_SPEED, 2'd0, 8'd10, 1'b0, 1'b0, 8'd0, 16'd0, 32'hFFFF_FF10));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'h0000_0030));
        // from standstill: straight to reversing, commit exactly at the wait
        row(mk(ACT_DIRECTION, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1000));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1099));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd4, 32'd1100));
        row(mk(ACT_ENABLE, 2'd0, 8'd0, 1'b0, 1'b1, 8'd0, 16'd0, 32'd1100));
        row(mk(ACT_SPEED, 2'd0, 8'd40, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1100));
        row(mk(ACT_BRAKE, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1100));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd5, 32'd1200));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd4, 32'd1200));
        row(mk(ACT_SPEED, 2'd0, 8'd30, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1200));
        row(mk(ACT_ENABLE, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1200));
        // live fault on tick, then clear attempts with and without live faults
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'h81, 16'd0, 32'd1300));
        row(mk(ACT_ENABLE, 2'd0, 8'd0, 1'b0, 1'b1, 8'd0, 16'd0, 32'd1300));
        row(mk(ACT_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0, 8'h01, 16'd0, 32'd1300));
        row(mk(ACT_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1300));
        row(mk(ACT_REPORT, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1300));
        row(mk(ACT_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1300));
        row(mk(ACT_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1300));
        // emergency stop ignores the motor index; clear from estop is allowed with live faults
        row(mk(ACT_ESTOP, 2'd3, 8'd0, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1400));
        row(mk(ACT_SPEED, 2'd0, 8'd5, 1'b0, 1'b0, 8'd0, 16'd0, 32'd1400));
        row(mk(ACT_TICK, 2'd0, 8'd0, 1'b0, 1'b0, 8'hFF, 16'd0, 32'd1400));
        row(mk(ACT_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0, 8'hFF, 16'd0, 32'd1400));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script_rows[k]) feed(script_rows[k].cmd, script_rows[k].typed,
                                      script_rows[k].want);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_MOTOR_COUNT, COUNT_SET[p]);
            write_reg(CFG_REVERSE_WAIT, WAIT_SET[p]);
            run_traffic(PHASE_ITEMS);
        end
        settle();
        repeat (8) @(posedge aclk);

        if (bad_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
